// ----- hdl/assert_macros.svh -----
// Assertion macros used by the lock manager datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);
// when ante holds, cons must hold in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- hdl/fmlm_pkg.sv -----
// Package: sizes, codes and controller/datapath interface types of the lock manager.
`default_nettype none

package fmlm_pkg;

  localparam int POOL_NODES   = 64;
  localparam int LOCK_ID_BITS = 8;
  localparam int PROC_ID_BITS = 8;

  // node index width, and pointer width that also holds the null link
  localparam int NODE_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int PTR_W  = NODE_W + 1;

  // one past the last node: null link, and the end value of the counters
  localparam logic [PTR_W-1:0] POOL_END = PTR_W'(POOL_NODES);

  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = ((LOCK_ID_BITS + PROC_ID_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((STATUS_W + 1 + PROC_ID_BITS + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_QUEUED     = 2'd1,
    ST_NOT_HOLDER = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  // read address source for the node memories
  typedef enum logic [1:0] {
    RD_SCAN = 2'd0,
    RD_HEAD = 2'd1,
    RD_WALK = 2'd2,
    RD_WAKE = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    req_load;   // capture request, restart scan
    logic    scan_step;  // issue next scan read
    rd_sel_t rd_sel;
    logic    walk_init;  // start tail walk at the head
    logic    walk_step;  // advance tail walk one node
    logic    link_we;    // next[tail] <= free node
    logic    fill_we;    // allocate free node
    logic    fill_tail;  // new node links back to the tail
    logic    rel_clr;    // free the head node
    logic    prev_nil;   // new head gets no previous node
    logic    set_res;    // latch pending result
    status_t res_status;
    logic    res_wake;
    logic    load_out;   // move pending result to output register
  } fmlm_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic head_found;
    logic owner_match;
    logic free_found;
    logic is_release;
    logic head_has_next;
    logic walk_go;
    logic out_free;
  } fmlm_sts_t;

endpackage

`default_nettype wire

// ----- hdl/fmlm_ctrl.sv -----
// Controller state machine of the lock manager.
`default_nettype none

module fmlm_ctrl
  import fmlm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire fmlm_sts_t sts,
  output fmlm_cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_WALK   = 8'b0000_1000,
    S_LINK   = 8'b0001_0000,
    S_FILL   = 8'b0010_0000,
    S_WAKE   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.rd_sel     = RD_SCAN;
    cmd.res_status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt   = S_DONE;
        cmd.set_res = 1'b1;
        if (!sts.is_release) begin
          if (!sts.head_found) begin
            // lock is free: take it with a fresh head node
            if (!sts.free_found) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.fill_we = 1'b1;
            end
          end else if (!sts.owner_match) begin
            if (!sts.free_found) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.set_res   = 1'b0;
              cmd.walk_init = 1'b1;
              cmd.rd_sel    = RD_HEAD;
              state_nxt     = S_WALK;
            end
          end
        end else begin
          if (!sts.head_found || !sts.owner_match) begin
            cmd.res_status = ST_NOT_HOLDER;
          end else begin
            cmd.rel_clr = 1'b1;
            if (sts.head_has_next) begin
              // promote the first waiter, fetch its owner for wake-up
              cmd.prev_nil = 1'b1;
              cmd.set_res  = 1'b0;
              cmd.rd_sel   = RD_WAKE;
              state_nxt    = S_WAKE;
            end
          end
        end
      end
      S_WALK: begin
        if (sts.walk_go) begin
          cmd.walk_step = 1'b1;
          cmd.rd_sel    = RD_WALK;
        end else begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        cmd.link_we = 1'b1;
        state_nxt   = S_FILL;
      end
      S_FILL: begin
        cmd.fill_we    = 1'b1;
        cmd.fill_tail  = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_QUEUED;
        state_nxt      = S_DONE;
      end
      S_WAKE: begin
        cmd.set_res  = 1'b1;
        cmd.res_wake = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fmlm_dpath.sv -----
// Datapath of the lock manager: node pool memories, scan, tail walk, result registers.
`default_nettype none

`include "assert_macros.svh"

module fmlm_dpath
  import fmlm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_mode,
  input  wire logic [LOCK_ID_BITS-1:0] in_lock,
  input  wire logic [PROC_ID_BITS-1:0] in_who,
  input  wire fmlm_cmd_t               cmd,
  output fmlm_sts_t                    sts,
  input  wire logic                    out_tready,
  output logic                         out_tvalid,
  output logic [OUT_TDATA_W-1:0]       out_tdata
);

  // node pool storage
  logic [POOL_NODES-1:0]   in_use_r;
  logic [PROC_ID_BITS-1:0] node_owner_mem [POOL_NODES];
  logic [LOCK_ID_BITS-1:0] node_lock_mem  [POOL_NODES];
  logic [PTR_W-1:0]        node_next_mem  [POOL_NODES];
  logic [PTR_W-1:0]        node_prev_mem  [POOL_NODES];

  // registered read port
  logic [NODE_W-1:0]       rd_addr;
  logic [NODE_W-1:0]       rd_idx_r;
  logic                    rd_use_r;
  logic [PROC_ID_BITS-1:0] rd_owner_r;
  logic [LOCK_ID_BITS-1:0] rd_lock_r;
  logic [PTR_W-1:0]        rd_next_r;
  logic [PTR_W-1:0]        rd_prev_r;

  // request
  logic                    req_mode_r;
  logic [LOCK_ID_BITS-1:0] req_lock_r;
  logic [PROC_ID_BITS-1:0] req_who_r;

  // scan results
  logic [PTR_W-1:0]        cnt_r;
  logic                    rd_vld_r;
  logic                    head_found_r;
  logic [NODE_W-1:0]       head_idx_r;
  logic [PROC_ID_BITS-1:0] head_owner_r;
  logic [PTR_W-1:0]        head_next_r;
  logic                    free_found_r;
  logic [NODE_W-1:0]       free_idx_r;
  logic                    head_hit;
  logic                    free_hit;

  // tail walk
  logic [NODE_W-1:0]       t_r;
  logic [PTR_W-1:0]        steps_r;

  // pending and output result
  status_t                 pend_status_r;
  logic                    pend_wake_r;
  logic [PROC_ID_BITS-1:0] pend_wake_id_r;
  status_t                 out_status_r;
  logic                    out_wake_r;
  logic [PROC_ID_BITS-1:0] out_wake_id_r;
  logic                    out_valid_r;

  // write port muxes
  logic [NODE_W-1:0]       next_waddr;
  logic [PTR_W-1:0]        next_wdata;
  logic [NODE_W-1:0]       prev_waddr;
  logic [PTR_W-1:0]        prev_wdata;

  // read address select
  always_comb begin
    unique case (cmd.rd_sel)
      RD_SCAN: rd_addr = cnt_r[NODE_W-1:0];
      RD_HEAD: rd_addr = head_idx_r;
      RD_WALK: rd_addr = rd_next_r[NODE_W-1:0];
      RD_WAKE: rd_addr = head_next_r[NODE_W-1:0];
      default: rd_addr = cnt_r[NODE_W-1:0];
    endcase
  end

  // next link write: link the tail, or terminate a new node
  assign next_waddr = cmd.link_we ? t_r : free_idx_r;
  assign next_wdata = cmd.link_we ? {1'b0, free_idx_r} : POOL_END;

  // prev link write: new node's back link, or promoted waiter becomes head
  assign prev_waddr = cmd.prev_nil ? head_next_r[NODE_W-1:0] : free_idx_r;
  assign prev_wdata = (cmd.fill_we && cmd.fill_tail) ? {1'b0, t_r} : POOL_END;

  // node memories
  always_ff @(posedge clk) begin
    if (cmd.fill_we) begin
      node_owner_mem[free_idx_r] <= req_who_r;
      node_lock_mem[free_idx_r]  <= req_lock_r;
    end
    if (cmd.fill_we || cmd.link_we) node_next_mem[next_waddr] <= next_wdata;
    if (cmd.fill_we || cmd.prev_nil) node_prev_mem[prev_waddr] <= prev_wdata;
    rd_owner_r <= node_owner_mem[rd_addr];
    rd_lock_r  <= node_lock_mem[rd_addr];
    rd_next_r  <= node_next_mem[rd_addr];
    rd_prev_r  <= node_prev_mem[rd_addr];
    rd_idx_r   <= rd_addr;
  end

  // in-use bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      rd_use_r <= 1'b0;
    end else begin
      if (cmd.fill_we) in_use_r[free_idx_r] <= 1'b1;
      if (cmd.rel_clr) in_use_r[head_idx_r] <= 1'b0;
      rd_use_r <= in_use_r[rd_addr];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_mode_r <= in_mode;
      req_lock_r <= in_lock;
      req_who_r  <= in_who;
    end
  end

  // pool scan: one node per cycle, first match wins
  assign head_hit = rd_vld_r && rd_use_r && (rd_lock_r == req_lock_r) &&
                    (rd_prev_r == POOL_END) && !head_found_r;
  assign free_hit = rd_vld_r && !rd_use_r && !free_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      head_found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.req_load) begin
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      head_found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (cmd.scan_step) begin
        if (cnt_r != POOL_END) begin
          cnt_r    <= cnt_r + 1'b1;
          rd_vld_r <= 1'b1;
        end else begin
          rd_vld_r <= 1'b0;
        end
      end
      if (head_hit) head_found_r <= 1'b1;
      if (free_hit) free_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_hit) begin
      head_idx_r   <= rd_idx_r;
      head_owner_r <= rd_owner_r;
      head_next_r  <= rd_next_r;
    end
    if (free_hit) free_idx_r <= rd_idx_r;
  end

  // tail walk: while walking, read data holds next[t_r]
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      t_r     <= head_idx_r;
      steps_r <= '0;
    end else if (cmd.walk_step) begin
      t_r     <= rd_next_r[NODE_W-1:0];
      steps_r <= steps_r + 1'b1;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      pend_status_r  <= cmd.res_status;
      pend_wake_r    <= cmd.res_wake;
      pend_wake_id_r <= cmd.res_wake ? rd_owner_r : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r  <= pend_status_r;
      out_wake_r    <= pend_wake_r;
      out_wake_id_r <= pend_wake_id_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_wake_id_r, out_wake_r, out_status_r});

  // status to controller
  assign sts.scan_done     = (cnt_r == POOL_END);
  assign sts.head_found    = head_found_r;
  assign sts.owner_match   = (head_owner_r == req_who_r);
  assign sts.free_found    = free_found_r;
  assign sts.is_release    = req_mode_r;
  assign sts.head_has_next = (head_next_r < POOL_END);
  assign sts.walk_go       = (rd_next_r < POOL_END) && (steps_r != POOL_END);
  assign sts.out_free      = !out_valid_r || out_tready;

  // checks
  `ASSERT_IMPLIES(a_fill_free, clk, rst_n, cmd.fill_we, free_found_r && !in_use_r[free_idx_r], "allocating a node that is in use")
  `ASSERT_IMPLIES(a_link_tail, clk, rst_n, cmd.link_we, in_use_r[t_r] && (t_r != free_idx_r), "tail link on a free node")
  `ASSERT_IMPLIES(a_rel_head, clk, rst_n, cmd.rel_clr, head_found_r && in_use_r[head_idx_r], "release of a head that is not held")
  `ASSERT_IMPLIES(a_load_slot, clk, rst_n, cmd.load_out, !out_valid_r || out_tready, "result overwrites an untaken result")

endmodule

`default_nettype wire

// ----- hdl/fifo_mutex_lock_manager.sv -----
// Every request scans the whole pool; a release that wakes a waiter adds a wake-up read, and
// a queued request adds a tail walk of at most POOL_NODES-2 nodes and then the link and fill
// writes. Scan and walk go one node per cycle through one read port. A new request is taken
// only when the last result has moved to the output register, which must first be free.
// Reset (rst_n low, synchronous) idles the controller, empties the output register and
// marks every pool node free at once; the node memories themselves keep no reset.
`default_nettype none

module fifo_mutex_lock_manager
  import fmlm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // lock_id, requester
  input  wire logic                   in_tuser,   // mode (0 acquire, 1 release)
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // status, wake_valid, wake_id
);

  fmlm_cmd_t cmd;
  fmlm_sts_t sts;

  fmlm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fmlm_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mode    (in_tuser),
    .in_lock    (in_tdata[LOCK_ID_BITS-1:0]),
    .in_who     (in_tdata[LOCK_ID_BITS +: PROC_ID_BITS]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ----- test/tb_fifo_mutex_lock_manager.sv -----
// Testbench for the FIFO-queued mutex lock manager: directed and random requests checked by a predictor.
`timescale 1ns / 100ps

module tb_fifo_mutex_lock_manager
  import fmlm_pkg::*;
();

  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;
  localparam int NO_NODE = POOL_NODES;

  localparam int RANDOM_ITEMS   = 2000;
  localparam int EPOCH_ITEMS    = 150;
  localparam int HOLD_AT        = 300;   // result count at which the long hold-off starts
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    status_t    status;
    logic       wake;
    logic [7:0] wake_id;
  } lock_reply_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  lock;
    logic [7:0]  who;
    logic        known;   // reply typed in below, else taken from the predictor
    lock_reply_t reply;
  } probe_row_t;

  // directed requests: empty pool, holder/waiter cases, lock and requester extremes
  localparam probe_row_t PROBE_ROWS [19] = '{
    '{MODE_RELEASE, 8'd0,   8'd0,   1'b1, '{ST_NOT_HOLDER, 1'b0, 8'd0}},
    '{MODE_ACQUIRE, 8'd0,   8'd0,   1'b1, '{ST_OK,         1'b0, 8'd0}},
    '{MODE_ACQUIRE, 8'd0,   8'd0,   1'b1, '{ST_OK,         1'b0, 8'd0}},
    '{MODE_ACQUIRE, 8'd0,   8'd255, 1'b1, '{ST_QUEUED,     1'b0, 8'd0}},
    '{MODE_ACQUIRE, 8'd0,   8'd255, 1'b1, '{ST_QUEUED,     1'b0, 8'd0}},
    '{MODE_RELEASE, 8'd0,   8'd255, 1'b1, '{ST_NOT_HOLDER, 1'b0, 8'd0}},
    '{MODE_RELEASE, 8'd0,   8'd0,   1'b1, '{ST_OK,         1'b1, 8'd255}},
    '{MODE_RELEASE, 8'd0,   8'd255, 1'b0, '{ST_OK,         1'b0, 8'd0}},
    '{MODE_RELEASE, 8'd0,   8'd255, 1'b0, '{ST_OK,         1'b0, 8'd0}},
    '{MODE_ACQUIRE, 8'd255, 8'd170, 1'b1, '{ST_OK,         1'b0, 8'd0}},
    '{MODE_ACQUIRE, 8'd255, 8'd85,  1'b1, '{ST_QUEUED,     1'b0, 8'd0}},
    '{MODE_ACQUIRE, 8'd255, 8'd0,   1'b0, '{ST_OK,         1'b0, 8'd0}},
    '{MODE_RELEASE, 8'd255, 8'd85,  1'b1, '{ST_NOT_HOLDER, 1'b0, 8'd0}},
    '{MODE_RELEASE, 8'd255, 8'd170, 1'b0, '{ST_OK,         1'b0, 8'd0}},
    '{MODE_RELEASE, 8'd255, 8'd85,  1'b0, '{ST_OK,         1'b0, 8'd0}},
    '{MODE_RELEASE, 8'd255, 8'd0,   1'b0, '{ST_OK,         1'b0, 8'd0}},
    '{MODE_ACQUIRE, 8'd128, 8'd1,   1'b1, '{ST_OK,         1'b0, 8'd0}},
    '{MODE_RELEASE, 8'd128, 8'd1,   1'b1, '{ST_OK,         1'b0, 8'd0}},
    '{MODE_RELEASE, 8'd255, 8'd0,   1'b1, '{ST_NOT_HOLDER, 1'b0, 8'd0}}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // lock_id, requester
  logic                   in_tuser = 1'b0; // mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // status, wake_valid, wake_id

  int  errors = 0;
  int  stall_cycles = 0;
  bit  no_gaps = 1'b0;
  int  acquire_pct = 50;

  // predicted node pool
  bit  pool_used  [POOL_NODES];
  int  pool_owner [POOL_NODES];
  int  pool_lock  [POOL_NODES];
  int  pool_next  [POOL_NODES];
  int  pool_prev  [POOL_NODES];

  lock_reply_t pending_replies [$];

  fifo_mutex_lock_manager DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // head of a lock's queue: lowest in-use node of that lock with no predecessor
  function automatic int head_of(input int lock);
    for (int i = 0; i < POOL_NODES; i++) begin
      if (pool_used[i] && pool_lock[i] == lock && pool_prev[i] == NO_NODE) return i;
    end
    return NO_NODE;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < POOL_NODES; i++) begin
      if (!pool_used[i]) return i;
    end
    return NO_NODE;
  endfunction

  // apply one request to the predicted pool and return the reply it gives
  function automatic lock_reply_t apply_request(input logic mode, input logic [7:0] lock,
                                                input logic [7:0] who);
    lock_reply_t r;
    int h, k, t, steps, n;
    r = '{ST_OK, 1'b0, 8'd0};
    h = head_of(lock);
    if (mode == MODE_ACQUIRE) begin
      if (h == NO_NODE || pool_owner[h] != who) begin
        k = free_slot();
        if (k == NO_NODE) begin
          r.status = ST_FULL;
        end else begin
          t = NO_NODE;
          if (h != NO_NODE) begin
            // append behind the current tail
            t = h;
            steps = 0;
            while (pool_next[t] != NO_NODE && steps < POOL_NODES) begin
              t = pool_next[t];
              steps++;
            end
            pool_next[t] = k;
            r.status = ST_QUEUED;
          end
          pool_used[k]  = 1'b1;
          pool_owner[k] = who;
          pool_lock[k]  = lock;
          pool_next[k]  = NO_NODE;
          pool_prev[k]  = t;
        end
      end
    end else if (h == NO_NODE || pool_owner[h] != who) begin
      r.status = ST_NOT_HOLDER;
    end else begin
      // free the holder, promote the next waiter
      n = pool_next[h];
      pool_used[h] = 1'b0;
      if (n != NO_NODE) begin
        pool_prev[n] = NO_NODE;
        r.wake = 1'b1;
        r.wake_id = 8'(pool_owner[n]);
      end
    end
    return r;
  endfunction

  function automatic int pick_held_head();
    int heads [$];
    for (int i = 0; i < POOL_NODES; i++) begin
      if (pool_used[i] && pool_prev[i] == NO_NODE) heads.push_back(i);
    end
    if (heads.size() == 0) return NO_NODE;
    return heads[$urandom_range(heads.size() - 1)];
  endfunction

  // offer one request after a random gap (none when no_gaps is set), then log its reply once taken
  task automatic offer_request(input logic mode, input logic [7:0] lock, input logic [7:0] who,
                               input logic known, input lock_reply_t known_reply);
    int gap;
    lock_reply_t r;
    gap = no_gaps ? 0 : $urandom_range(13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {who, lock};
    do @(posedge clk); while (!in_tready);
    r = apply_request(mode, lock, who);
    pending_replies.push_back(known ? known_reply : r);
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // random request: acquires mostly on a few locks, releases mostly by the holder
  task automatic random_request();
    logic       mode;
    logic [7:0] lock, who;
    int h, r;
    if ($urandom_range(99) < acquire_pct) begin
      mode = MODE_ACQUIRE;
      lock = ($urandom_range(9) < 8) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
      h = head_of(lock);
      r = $urandom_range(9);
      if (h != NO_NODE && r == 0) who = 8'(pool_owner[h]);
      else if (r < 7) who = 8'($urandom_range(15));
      else who = 8'($urandom_range(255));
    end else begin
      mode = MODE_RELEASE;
      h = pick_held_head();
      if (h != NO_NODE && $urandom_range(9) < 8) begin
        lock = 8'(pool_lock[h]);
        who  = 8'(pool_owner[h]);
      end else begin
        lock = ($urandom_range(3) != 0) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
        who  = ($urandom_range(3) != 0) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      end
    end
    offer_request(mode, lock, who, 1'b0, '{ST_OK, 1'b0, 8'd0});
  endtask

  // request side
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (PROBE_ROWS[i]) begin
      offer_request(PROBE_ROWS[i].mode, PROBE_ROWS[i].lock, PROBE_ROWS[i].who,
                    PROBE_ROWS[i].known, PROBE_ROWS[i].reply);
    end
    drain_replies();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // each epoch sets the acquire/release balance and whether gaps are used
      if (i % EPOCH_ITEMS == 0) begin
        case ($urandom_range(3))
          0: acquire_pct = 35;
          1: acquire_pct = 60;
          2: acquire_pct = 80;
          default: acquire_pct = 100;
        endcase
        if (i == EPOCH_ITEMS) acquire_pct = 100;  // make sure the pool runs full
        no_gaps = ($urandom_range(3) == 0);
      end
      if (i == RANDOM_ITEMS / 2) drain_replies();
      random_request();
    end
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off, field-by-field check
  initial begin
    int gap;
    int taken;
    lock_reply_t got, want;
    taken = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = no_gaps ? 0 : $urandom_range(13);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      got.status  = status_t'(out_tdata[1:0]);
      got.wake    = out_tdata[2];
      got.wake_id = out_tdata[10:3];
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply, status %0d wake %0b id %0d",
                 $time, got.status, got.wake, got.wake_id);
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        end
        if (got.wake !== want.wake) begin
          errors++;
          $display("%0t: wake_valid expected %0b, got %0b", $time, want.wake, got.wake);
        end
        if (got.wake_id !== want.wake_id) begin
          errors++;
          $display("%0t: wake_id expected %0d, got %0d", $time, want.wake_id, got.wake_id);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/fmlm_pkg.sv
hdl/fmlm_ctrl.sv
hdl/fmlm_dpath.sv
hdl/fifo_mutex_lock_manager.sv
test/tb_fifo_mutex_lock_manager.sv
